// File: design/pht_pkg.sv
`default_nettype none

package pht_pkg;

  // pipeline shape
  localparam int unsigned NUM_STAGES = 8;
  localparam int unsigned STG_W      = $clog2(NUM_STAGES);
  localparam int unsigned REG_W      = 5;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned NOW_W      = 6;
  localparam int unsigned NUM_HAZ    = 4;

  // stage numbers
  localparam logic [STG_W-1:0] ST_ID   = STG_W'(2);
  localparam logic [STG_W-1:0] ST_EXE1 = STG_W'(3);
  localparam logic [STG_W-1:0] ST_MEM2 = STG_W'(6);

  // cycle counter starts with the pipe already filled
  localparam logic [CNT_W-1:0] CYCLE_RST = CNT_W'(NUM_STAGES - 1);

  // command codes
  localparam logic [2:0] CMD_CLOCK = 3'd0;
  localparam logic [2:0] CMD_SRC   = 3'd1;
  localparam logic [2:0] CMD_DEST  = 3'd2;
  localparam logic [2:0] CMD_FLUSH = 3'd3;
  localparam logic [2:0] CMD_STALL = 3'd4;

  // one pipe stage as seen by the scan
  typedef struct packed {
    logic             vld;
    logic [REG_W-1:0] rnum;
    logic [STG_W-1:0] ready;
  } stage_ent_t;

  // operation applied to the pipe in one cycle
  typedef struct packed {
    logic             advance;
    logic             bubble;
    logic             write_id;
    logic [REG_W-1:0] wr_reg;
    logic [STG_W-1:0] wr_ready;
  } pipe_op_t;

  // incoming request fields
  typedef struct packed {
    logic [2:0]       cmd;
    logic [REG_W-1:0] rnum;
    logic [STG_W-1:0] stg;
    logic [7:0]       rep;
  } req_t;

  // running counters handed to the result register
  typedef struct packed {
    logic [CNT_W-1:0]              cycle;
    logic [CNT_W-1:0]              bubble;
    logic [CNT_W-1:0]              flush;
    logic [CNT_W-1:0]              stall;
    logic [NOW_W-1:0]              now;
    logic [NUM_HAZ-1:0][CNT_W-1:0] haz;
  } cnt_bundle_t;

endpackage

`default_nettype wire

// File: design/pht_stages.sv
`default_nettype none

module pht_stages (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pht_pkg::pipe_op_t  op,
  input  wire logic [pht_pkg::STG_W-1:0] rd_idx,
  output pht_pkg::stage_ent_t     rd_ent
);
  import pht_pkg::*;

  logic [NUM_STAGES-1:0] vld_r, vld_nxt;
  logic [REG_W-1:0]      rnum_r  [NUM_STAGES];
  logic [REG_W-1:0]      rnum_nxt[NUM_STAGES];
  logic [STG_W-1:0]      rdy_r   [NUM_STAGES];
  logic [STG_W-1:0]      rdy_nxt [NUM_STAGES];

  // shift, bubble or id write
  always_comb begin
    vld_nxt = vld_r;
    for (int i = 0; i < NUM_STAGES; i++) begin
      rnum_nxt[i] = rnum_r[i];
      rdy_nxt[i]  = rdy_r[i];
    end
    if (op.advance) begin
      for (int i = 1; i < NUM_STAGES; i++) begin
        vld_nxt[i]  = vld_r[i-1];
        rnum_nxt[i] = rnum_r[i-1];
        rdy_nxt[i]  = rdy_r[i-1];
      end
      vld_nxt[0] = 1'b0;
    end else if (op.bubble) begin
      for (int i = int'(ST_EXE1) + 1; i < NUM_STAGES; i++) begin
        vld_nxt[i]  = vld_r[i-1];
        rnum_nxt[i] = rnum_r[i-1];
        rdy_nxt[i]  = rdy_r[i-1];
      end
      vld_nxt[ST_EXE1] = 1'b0;
    end else if (op.write_id) begin
      vld_nxt[ST_ID]  = 1'b1;
      rnum_nxt[ST_ID] = op.wr_reg;
      rdy_nxt[ST_ID]  = op.wr_ready;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_STAGES; i++) begin
      rnum_r[i] <= rnum_nxt[i];
      rdy_r[i]  <= rdy_nxt[i];
    end
  end

  // scan read port
  assign rd_ent.vld   = vld_r[rd_idx];
  assign rd_ent.rnum  = rnum_r[rd_idx];
  assign rd_ent.ready = rdy_r[rd_idx];

endmodule

`default_nettype wire

// File: design/pht_ctrl.sv
`default_nettype none

module pht_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 req_valid,
  input  wire pht_pkg::req_t        req,
  output logic                      req_stall,
  input  wire logic                 out_free,
  output logic                      done,
  output pht_pkg::cnt_bundle_t      cnt,
  output pht_pkg::pipe_op_t         op,
  output logic [pht_pkg::STG_W-1:0] rd_idx,
  input  wire pht_pkg::stage_ent_t  rd_ent
);
  import pht_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DISP = 6'b000010,
    S_SCAN = 6'b000100,
    S_BUB  = 6'b001000,
    S_ADV  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t                        state_r, state_nxt;
  req_t                          req_r, req_nxt;
  logic [STG_W-1:0]              idx_r, idx_nxt;
  logic [2:0]                    bub_r, bub_nxt;
  logic [7:0]                    rep_r, rep_nxt;
  logic [CNT_W-1:0]              cycle_r, cycle_nxt;
  logic [CNT_W-1:0]              bubble_r, bubble_nxt;
  logic [CNT_W-1:0]              flush_r, flush_nxt;
  logic [CNT_W-1:0]              stall_r, stall_nxt;
  logic [NOW_W-1:0]              now_r, now_nxt;
  logic [NUM_HAZ-1:0][CNT_W-1:0] haz_r, haz_nxt;

  logic                          match;
  logic [4:0]                    b_sum, b_sub, b_diff;
  logic                          need_bub;
  logic [1:0]                    haz_sel;

  // shared compare and subtract: bubbles owed by the scanned stage
  assign match    = rd_ent.vld && (rd_ent.rnum == req_r.rnum);
  assign b_sum    = {2'b00, rd_ent.ready} + 5'd2;
  assign b_sub    = {2'b00, idx_r} + {2'b00, req_r.stg};
  assign b_diff   = b_sum - b_sub;
  assign need_bub = match && (b_sum > b_sub);
  assign haz_sel  = 2'(idx_r - ST_EXE1);

  assign rd_idx    = idx_r;
  assign req_stall = (state_r != S_IDLE);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    idx_nxt     = idx_r;
    bub_nxt     = bub_r;
    rep_nxt     = rep_r;
    cycle_nxt   = cycle_r;
    bubble_nxt  = bubble_r;
    flush_nxt   = flush_r;
    stall_nxt   = stall_r;
    now_nxt     = now_r;
    haz_nxt     = haz_r;
    op          = '0;
    op.wr_reg   = req_r.rnum;
    op.wr_ready = req_r.stg;
    done        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          req_nxt   = req;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        now_nxt   = '0;
        idx_nxt   = ST_EXE1;
        rep_nxt   = req_r.rep;
        state_nxt = S_FIN;
        case (req_r.cmd)
          CMD_CLOCK: begin
            op.advance = 1'b1;
            cycle_nxt  = cycle_r + 32'd1;
          end
          CMD_SRC: begin
            if (req_r.rnum != '0) begin
              state_nxt = S_SCAN;
            end
          end
          CMD_DEST: begin
            op.write_id = 1'b1;
          end
          CMD_FLUSH, CMD_STALL: begin
            if (req_r.rep != 8'd0) begin
              state_nxt = S_ADV;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        if (match) begin
          haz_nxt[haz_sel] = haz_r[haz_sel] + 32'd1;
        end
        if (need_bub) begin
          bub_nxt   = b_diff[2:0];
          state_nxt = S_BUB;
        end else if (idx_r == ST_MEM2) begin
          state_nxt = S_FIN;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
      S_BUB: begin
        op.bubble  = 1'b1;
        cycle_nxt  = cycle_r + 32'd1;
        bubble_nxt = bubble_r + 32'd1;
        now_nxt    = now_r + 6'd1;
        bub_nxt    = bub_r - 3'd1;
        if (bub_r == 3'd1) begin
          if (idx_r == ST_MEM2) begin
            state_nxt = S_FIN;
          end else begin
            idx_nxt   = idx_r + 3'd1;
            state_nxt = S_SCAN;
          end
        end
      end
      S_ADV: begin
        op.advance = 1'b1;
        cycle_nxt  = cycle_r + 32'd1;
        rep_nxt    = rep_r - 8'd1;
        if (req_r.cmd == CMD_FLUSH) begin
          flush_nxt = flush_r + 32'd1;
        end else begin
          stall_nxt = stall_r + 32'd1;
        end
        if (rep_r == 8'd1) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cycle_r  <= CYCLE_RST;
      bubble_r <= '0;
      flush_r  <= '0;
      stall_r  <= '0;
      haz_r    <= '0;
      now_r    <= '0;
      bub_r    <= '0;
      rep_r    <= '0;
      idx_r    <= ST_EXE1;
    end else begin
      state_r  <= state_nxt;
      cycle_r  <= cycle_nxt;
      bubble_r <= bubble_nxt;
      flush_r  <= flush_nxt;
      stall_r  <= stall_nxt;
      haz_r    <= haz_nxt;
      now_r    <= now_nxt;
      bub_r    <= bub_nxt;
      rep_r    <= rep_nxt;
      idx_r    <= idx_nxt;
    end
  end

  // latched request
  always_ff @(posedge clk) begin
    req_r <= req_nxt;
  end

  assign cnt.cycle  = cycle_r;
  assign cnt.bubble = bubble_r;
  assign cnt.flush  = flush_r;
  assign cnt.stall  = stall_r;
  assign cnt.now    = now_r;
  assign cnt.haz    = haz_r;

  // scan index stays on the producer stages
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (idx_r >= ST_EXE1 && idx_r <= ST_MEM2))
    else $error("scan index outside exe1..mem2");

  // a bubble state always owes at least one bubble
  a_bub_owed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BUB) |-> (bub_r != 3'd0))
    else $error("bubble state with nothing owed");

  // each bubble adds one to the per-request bubble count
  a_bub_now: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BUB) |=> (now_r == $past(now_r) + 6'd1))
    else $error("bubbles_now did not step");

  // repeat loop always has cycles left and ticks the cycle counter
  a_adv_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADV) |-> (rep_r != 8'd0) ##1 (cycle_r == $past(cycle_r) + 32'd1))
    else $error("repeat loop out of step");

endmodule

`default_nettype wire

// File: design/pipeline_hazard_tracker_core.sv
`default_nettype none

// channel  | direction | handshake            | payload
// in_      | request   | in_valid / in_stall   | cmd, reg_num, stage_index, repeat_count
// out_     | result    | out_valid / out_stall | totals, bubbles_now, hazards per stage
//
// one request at a time; in_stall is high from acceptance until the result is loaded
// clock, destination write, unused codes, source of register zero: dispatch, then the
//   final load; out_valid rises as in_stall drops, and the next request can be taken
// source read: one stage compared per cycle, exe1 to mem2, pausing for owed bubbles
// flush or stall: repeat_count pipe advances, one per cycle
// a held result stalls only the final load; reset is synchronous and empties the pipe

module pipeline_hazard_tracker_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [4:0]  in_reg_num,
  input  wire logic [2:0]  in_stage_index,
  input  wire logic [7:0]  in_repeat_count,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_cycle_total,
  output logic [31:0]      out_bubble_total,
  output logic [31:0]      out_flush_total,
  output logic [31:0]      out_stall_total,
  output logic [5:0]       out_bubbles_now,
  output logic [31:0]      out_hazards_exe1,
  output logic [31:0]      out_hazards_exe2,
  output logic [31:0]      out_hazards_mem1,
  output logic [31:0]      out_hazards_mem2
);
  import pht_pkg::*;

  req_t             req;
  pipe_op_t         op;
  stage_ent_t       rd_ent;
  logic [STG_W-1:0] rd_idx;
  cnt_bundle_t      cnt;
  cnt_bundle_t      res_r;
  logic             done;
  logic             out_free;
  logic             out_valid_r, out_valid_nxt;

  assign req.cmd  = in_cmd;
  assign req.rnum = in_reg_num;
  assign req.stg  = in_stage_index;
  assign req.rep  = in_repeat_count;

  // sequencer with counters and shared compare unit
  pht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req       (req),
    .req_stall (in_stall),
    .out_free  (out_free),
    .done      (done),
    .cnt       (cnt),
    .op        (op),
    .rd_idx    (rd_idx),
    .rd_ent    (rd_ent)
  );

  // eight-stage scoreboard
  pht_stages u_stages (
    .clk    (clk),
    .rst_n  (rst_n),
    .op     (op),
    .rd_idx (rd_idx),
    .rd_ent (rd_ent)
  );

  // result register
  assign out_free      = !out_valid_r || !out_stall;
  assign out_valid_nxt = done || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      res_r <= cnt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cycle_total  = res_r.cycle;
  assign out_bubble_total = res_r.bubble;
  assign out_flush_total  = res_r.flush;
  assign out_stall_total  = res_r.stall;
  assign out_bubbles_now  = res_r.now;
  assign out_hazards_exe1 = res_r.haz[0];
  assign out_hazards_exe2 = res_r.haz[1];
  assign out_hazards_mem1 = res_r.haz[2];
  assign out_hazards_mem2 = res_r.haz[3];

endmodule

`default_nettype wire

// File: sim/testbench.sv
module testbench;
  import pht_pkg::*;

  // command codes the block does not define
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  localparam int unsigned TICK_LIMIT = 600000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned PHASE_ITEMS = 135;

  // one directed request, with the expected totals where they are obvious
  typedef struct packed {
    logic [2:0]  cmd;
    logic [4:0]  rnum;
    logic [2:0]  stg;
    logic [7:0]  rep;
    logic        typed;
    logic [31:0] cyc;
    logic [31:0] bub;
    logic [31:0] fl;
    logic [31:0] st;
    logic [5:0]  now;
    logic [31:0] h_exe1;
    logic [31:0] h_exe2;
    logic [31:0] h_mem1;
    logic [31:0] h_mem2;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_cmd = '0;
  logic [4:0]  in_reg_num = '0;
  logic [2:0]  in_stage_index = '0;
  logic [7:0]  in_repeat_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_cycle_total;
  logic [31:0] out_bubble_total;
  logic [31:0] out_flush_total;
  logic [31:0] out_stall_total;
  logic [5:0]  out_bubbles_now;
  logic [31:0] out_hazards_exe1;
  logic [31:0] out_hazards_exe2;
  logic [31:0] out_hazards_mem1;
  logic [31:0] out_hazards_mem2;

  // shadow copy of the pipe and the running totals
  stage_ent_t  shadow_pipe [NUM_STAGES];
  cnt_bundle_t run_tally;
  cnt_bundle_t tally_q [$];
  cnt_bundle_t head_tally;

  int unsigned mismatch_count = 0;
  int unsigned tick_count = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned hold_asks = 0;
  int unsigned hold_done = 0;
  int unsigned hold_left = 0;

  plan_row_t directed_plan [0:24] = '{
    '{CMD_CLOCK,     0, 0,   0, 1,   8, 0,   0,   0, 0, 1'b0, 0, 0, 0},
    '{CMD_SPARE_LO, 31, 7, 255, 1,   8, 0,   0,   0, 0, 0, 0, 0, 0},
    '{CMD_SPARE_HI,  0, 0,   0, 1,   8, 0,   0,   0, 0, 0, 0, 0, 0},
    '{CMD_FLUSH,     0, 0,   0, 1,   8, 0,   0,   0, 0, 0, 0, 0, 0},
    '{CMD_STALL,     0, 0,   0, 1,   8, 0,   0,   0, 0, 0, 0, 0, 0},
    '{CMD_DEST,     31, 7,   0, 1,   8, 0,   0,   0, 0, 0, 0, 0, 0},
    '{CMD_CLOCK,     0, 0,   0, 1,   9, 0,   0,   0, 0, 0, 0, 0, 0},
    '{CMD_SRC,      31, 0,   0, 1,  15, 6,   0,   0, 6, 1, 0, 0, 0},
    '{CMD_FLUSH,     0, 0, 255, 1, 270, 6, 255,   0, 0, 1, 0, 0, 0},
    '{CMD_STALL,     0, 0, 255, 1, 525, 6, 255, 255, 0, 1, 0, 0, 0},
    '{CMD_DEST,      0, 7,   0, 1, 525, 6, 255, 255, 0, 1, 0, 0, 0},
    '{CMD_CLOCK,     0, 0,   0, 1, 526, 6, 255, 255, 0, 1, 0, 0, 0},
    '{CMD_SRC,       0, 0,   0, 1, 526, 6, 255, 255, 0, 1, 0, 0, 0},
    '{CMD_DEST,      1, 5,   0, 0,   0, 0,   0,   0, 0, 0, 0, 0, 0},
    '{CMD_CLOCK,     0, 0,   0, 0,   0, 0,   0,   0, 0, 0, 0, 0, 0},
    '{CMD_CLOCK,     0, 0,   0, 0,   0, 0,   0,   0, 0, 0, 0, 0, 0},
    '{CMD_SRC,       1, 3,   0, 0,   0, 0,   0,   0, 0, 0, 0, 0, 0},
    '{CMD_DEST,      2, 6,   0, 0,   0, 0,   0,   0, 0, 0, 0, 0, 0},
    '{CMD_CLOCK,     0, 0,   0, 0,   0, 0,   0,   0, 0, 0, 0, 0, 0},
    '{CMD_CLOCK,     0, 0,   0, 0,   0, 0,   0,   0, 0, 0, 0, 0, 0},
    '{CMD_CLOCK,     0, 0,   0, 0,   0, 0,   0,   0, 0, 0, 0, 0, 0},
    '{CMD_SRC,       2, 2,   0, 0,   0, 0,   0,   0, 0, 0, 0, 0, 0},
    '{CMD_DEST,     16, 0,   0, 0,   0, 0,   0,   0, 0, 0, 0, 0, 0},
    '{CMD_CLOCK,     0, 0,   0, 0,   0, 0,   0,   0, 0, 0, 0, 0, 0},
    '{CMD_SRC,      16, 7,   0, 0,   0, 0,   0,   0, 0, 0, 0, 0, 0}
  };

  pipeline_hazard_tracker_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_reg_num       (in_reg_num),
    .in_stage_index   (in_stage_index),
    .in_repeat_count  (in_repeat_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_cycle_total  (out_cycle_total),
    .out_bubble_total (out_bubble_total),
    .out_flush_total  (out_flush_total),
    .out_stall_total  (out_stall_total),
    .out_bubbles_now  (out_bubbles_now),
    .out_hazards_exe1 (out_hazards_exe1),
    .out_hazards_exe2 (out_hazards_exe2),
    .out_hazards_mem1 (out_hazards_mem1),
    .out_hazards_mem2 (out_hazards_mem2)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // whole pipe moves one stage, empty slot enters at the front
  function automatic void pipe_advance();
    run_tally.cycle = run_tally.cycle + 1;
    for (int s = NUM_STAGES - 1; s > 0; s--) shadow_pipe[s] = shadow_pipe[s-1];
    shadow_pipe[0] = '0;
  endfunction

  // front end frozen, back end shifts, empty slot enters at exe1
  function automatic void pipe_bubble();
    run_tally.cycle  = run_tally.cycle + 1;
    run_tally.bubble = run_tally.bubble + 1;
    for (int s = NUM_STAGES - 1; s > int'(ST_EXE1); s--) shadow_pipe[s] = shadow_pipe[s-1];
    shadow_pipe[ST_EXE1] = '0;
  endfunction

  // apply one request to the shadow pipe and return the totals it reports
  function automatic cnt_bundle_t predict_tally(input logic [2:0] cmd,
                                                input logic [4:0] rnum,
                                                input logic [2:0] stg,
                                                input logic [7:0] rep);
    int inserted;
    int gap;
    inserted = 0;
    case (cmd)
      CMD_CLOCK: begin
        pipe_advance();
      end
      CMD_SRC: begin
        // register zero never matches; the scan walks the pipe as it shifts
        if (rnum != '0) begin
          for (int s = int'(ST_EXE1); s <= int'(ST_MEM2); s++) begin
            if (shadow_pipe[s].vld && shadow_pipe[s].rnum == rnum) begin
              gap = (int'(shadow_pipe[s].ready) - s) - (int'(stg) - int'(ST_ID));
              run_tally.haz[s - int'(ST_EXE1)] = run_tally.haz[s - int'(ST_EXE1)] + 1;
              while (gap > 0) begin
                pipe_bubble();
                inserted++;
                gap--;
              end
            end
          end
        end
      end
      CMD_DEST: begin
        shadow_pipe[ST_ID].vld   = 1'b1;
        shadow_pipe[ST_ID].rnum  = rnum;
        shadow_pipe[ST_ID].ready = stg;
      end
      CMD_FLUSH: begin
        repeat (rep) begin
          pipe_advance();
          run_tally.flush = run_tally.flush + 1;
        end
      end
      CMD_STALL: begin
        repeat (rep) begin
          pipe_advance();
          run_tally.stall = run_tally.stall + 1;
        end
      end
      default: begin
      end
    endcase
    run_tally.now = NOW_W'(inserted);
    return run_tally;
  endfunction

  // present one request and hold it until the block takes it
  task automatic offer_request(input logic [2:0] cmd, input logic [4:0] rnum,
                               input logic [2:0] stg, input logic [7:0] rep);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= cmd;
    in_reg_num      <= rnum;
    in_stage_index  <= stg;
    in_repeat_count <= rep;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic issue_request(input logic [2:0] cmd, input logic [4:0] rnum,
                               input logic [2:0] stg, input logic [7:0] rep);
    offer_request(cmd, rnum, stg, rep);
    tally_q.push_back(predict_tally(cmd, rnum, stg, rep));
  endtask

  // mostly short counts, now and then up to the full range
  function automatic logic [7:0] pick_repeat();
    if ($urandom_range(9) == 0) return 8'($urandom_range(255));
    return 8'($urandom_range(12));
  endfunction

  // producer/consumer sequences with random content, plus loose noise
  task automatic hazard_burst(input int unsigned n_items);
    int unsigned done;
    logic [4:0]  r_a;
    logic [4:0]  r_b;
    logic [2:0]  cmd;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(99) < 70) begin
        r_a = 5'($urandom_range(1, 31));
        if ($urandom_range(19) == 0) r_a = '0;
        r_b = r_a;
        issue_request(CMD_DEST, r_a, 3'($urandom_range(7)), 8'($urandom_range(255)));
        done++;
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(3) == 0) begin
            r_b = 5'($urandom_range(31));
            issue_request(CMD_DEST, r_b, 3'($urandom_range(7)), 8'($urandom_range(255)));
            done++;
          end
          issue_request(CMD_CLOCK, 5'($urandom_range(31)), 3'($urandom_range(7)),
                        8'($urandom_range(255)));
          done++;
        end
        issue_request(CMD_SRC, $urandom_range(1) ? r_a : r_b, 3'($urandom_range(7)),
                      8'($urandom_range(255)));
        done++;
        if ($urandom_range(1) == 0) begin
          issue_request(CMD_SRC, r_a, 3'($urandom_range(7)), 8'($urandom_range(255)));
          done++;
        end
      end else begin
        cmd = 3'($urandom_range(7));
        issue_request(cmd, 5'($urandom_range(31)), 3'($urandom_range(7)),
                      (cmd == CMD_FLUSH || cmd == CMD_STALL) ? pick_repeat()
                                                             : 8'($urandom_range(255)));
        done++;
      end
    end
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (tally_q.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, or a long hold-off when one is asked for
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asks != hold_done) begin
      hold_done <= hold_asks;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < snk_stall_pct);
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (tally_q.size() == 0) begin
        $error("result with no request pending: cycle_total %0d", out_cycle_total);
        mismatch_count++;
      end else begin
        head_tally = tally_q.pop_front();
        check_field("cycle_total", head_tally.cycle, out_cycle_total);
        check_field("bubble_total", head_tally.bubble, out_bubble_total);
        check_field("flush_total", head_tally.flush, out_flush_total);
        check_field("stall_total", head_tally.stall, out_stall_total);
        check_field("bubbles_now", 32'(head_tally.now), 32'(out_bubbles_now));
        check_field("hazards_exe1", head_tally.haz[0], out_hazards_exe1);
        check_field("hazards_exe2", head_tally.haz[1], out_hazards_exe2);
        check_field("hazards_mem1", head_tally.haz[2], out_hazards_mem1);
        check_field("hazards_mem2", head_tally.haz[3], out_hazards_mem2);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    tick_count <= tick_count + 1;
    if (tick_count == TICK_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    plan_row_t   row;
    cnt_bundle_t want;
    int unsigned idle_by_phase [4];
    int unsigned stall_by_phase [4];
    idle_by_phase  = '{0, 46, 0, 16};
    stall_by_phase = '{0, 0, 46, 16};

    // shadow state after reset
    foreach (shadow_pipe[s]) shadow_pipe[s] = '0;
    run_tally       = '0;
    run_tally.cycle = CYCLE_RST;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      offer_request(row.cmd, row.rnum, row.stg, row.rep);
      want = predict_tally(row.cmd, row.rnum, row.stg, row.rep);
      if (row.typed) begin
        want.cycle  = row.cyc;
        want.bubble = row.bub;
        want.flush  = row.fl;
        want.stall  = row.st;
        want.now    = row.now;
        want.haz[0] = row.h_exe1;
        want.haz[1] = row.h_exe2;
        want.haz[2] = row.h_mem1;
        want.haz[3] = row.h_mem2;
      end
      tally_q.push_back(want);
    end
    wait_all_results();

    // random phases with different idle patterns
    for (int p = 0; p < 4; p++) begin
      src_idle_pct  = idle_by_phase[p];
      snk_stall_pct = stall_by_phase[p];
      // long receiver hold-off while requests keep coming
      if (p == 0) hold_asks <= hold_asks + 1;
      hazard_burst(PHASE_ITEMS);
      wait_all_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
